// File: hw/rtl/bcl_pkg.sv
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared codes and field positions of the buffer cache LRU manager.
// ----------------------------------------------------------------------------
package bcl_pkg;

   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;

   // Request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_GET       = 3'd0,
      MODE_RELEASE   = 3'd1,
      MODE_FILL      = 3'd2,
      MODE_PIN       = 3'd3,
      MODE_WRITEBACK = 3'd4
   } mode_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_READY    = 3'd0,
      ST_NEEDREAD = 3'd1,
      ST_WAIT     = 3'd2,
      ST_NONEFREE = 3'd3,
      ST_DONE     = 3'd4,
      ST_ERROR    = 3'd5
   } status_type;

   // Bit positions in a slot record: flags first, then device, then sector
   localparam int REC_USED  = 0;
   localparam int REC_BUSY  = 1;
   localparam int REC_VALID = 2;
   localparam int REC_DIRTY = 3;
   localparam int REC_FLAGS = 4;

endpackage

// File: hw/rtl/bcl_req_if.sv
// ----------------------------------------------------------------------------
// bcl_req_if
// Request channel: valid/ready handshake carrying mode, device, sector, slot.
// ----------------------------------------------------------------------------
interface bcl_req_if #(
   parameter int DEVICE_BITS = 2,
   parameter int SECTOR_BITS = 10
);
   logic                         valid;
   logic                         ready;
   logic [bcl_pkg::MODE_W-1:0]   mode;
   logic [DEVICE_BITS-1:0]       dev;
   logic [SECTOR_BITS-1:0]       sector;
   logic [bcl_pkg::SLOT_W-1:0]   slot;

   modport source (output valid, mode, dev, sector, slot, input ready);
   modport sink   (input valid, mode, dev, sector, slot, output ready);
endinterface

// File: hw/rtl/bcl_rsp_if.sv
// ----------------------------------------------------------------------------
// bcl_rsp_if
// Response channel: valid/ready handshake carrying status and slot.
// ----------------------------------------------------------------------------
interface bcl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bcl_pkg::STATUS_W-1:0]  status;
   logic [bcl_pkg::SLOT_W-1:0]    slot_out;

   modport source (output valid, status, slot_out, input ready);
   modport sink   (input valid, status, slot_out, output ready);
endinterface

// File: hw/rtl/bcl_ram.sv
// ----------------------------------------------------------------------------
// bcl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         q_ff <= mem_ff[raddr];
      end
   end

   assign rdata = q_ff;

endmodule

// File: hw/rtl/bcl_tag_store.sv
// ----------------------------------------------------------------------------
// bcl_tag_store
// Slot record memory (tag and flags); unwritten entries read as all zero.
// ----------------------------------------------------------------------------
module bcl_tag_store #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             vld_q_ff, vld_q_in;
   logic [WIDTH-1:0] ram_q;

   bcl_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (ram_q)
   );

   always_comb begin
      vld_in = vld_ff;
      if (we) begin
         vld_in[waddr] = 1'b1;
      end
      vld_q_in = re ? vld_ff[raddr] : vld_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         vld_q_ff <= vld_q_in;
      end
   end

   assign rdata = vld_q_ff ? ram_q : '0;

endmodule

// File: hw/rtl/bcl_order_store.sv
// ----------------------------------------------------------------------------
// bcl_order_store
// Recency list memory, position 0 most recent; unwritten positions read as
// their own index.
// ----------------------------------------------------------------------------
module bcl_order_store #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [$clog2(DEPTH)-1:0] wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [$clog2(DEPTH)-1:0] rdata
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             vld_q_ff, vld_q_in;
   logic [IDX_W-1:0] raddr_ff, raddr_in;
   logic [IDX_W-1:0] ram_q;

   bcl_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (ram_q)
   );

   always_comb begin
      vld_in = vld_ff;
      if (we) begin
         vld_in[waddr] = 1'b1;
      end
      vld_q_in = re ? vld_ff[raddr] : vld_q_ff;
      raddr_in = re ? raddr : raddr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         vld_q_ff <= vld_q_in;
      end
      raddr_ff <= raddr_in;
   end

   assign rdata = vld_q_ff ? ram_q : raddr_ff;

endmodule

// File: hw/rtl/buffer_cache_lru_manager.sv
// A new request is accepted only in the idle state, once the previous result
// is registered for the reply; a receiver holding off a ready result delays it.
// Flag requests (fill done, pin dirty, write back, errors) end in the check state.
// Get walks the recency list one position a cycle through the order and
// record memories; a hit ends the walk early, a miss walks the whole list.
// Release rewrites the list up to the released slot's position. Sync reset.
// ----------------------------------------------------------------------------
// buffer_cache_lru_manager
// Tag and recency manager for a block buffer cache of SLOT_COUNT slots.
// ----------------------------------------------------------------------------
module buffer_cache_lru_manager #(
   parameter int SLOT_COUNT  = 16,
   parameter int SECTOR_BITS = 10,
   parameter int DEVICE_BITS = 2
) (
   input  logic       clock,
   input  logic       reset,
   bcl_req_if.sink    req_chan,
   bcl_rsp_if.source  rsp_chan
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int CNT_W  = IDX_W + 1;
   localparam int SW     = bcl_pkg::SLOT_W;
   localparam int DEV_LO = bcl_pkg::REC_FLAGS;
   localparam int SEC_LO = bcl_pkg::REC_FLAGS + DEVICE_BITS;
   localparam int REC_W  = bcl_pkg::REC_FLAGS + DEVICE_BITS + SECTOR_BITS;
   localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(SLOT_COUNT);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_COUNT - 1);
   localparam logic [7:0]       SLOT_LIMIT = 8'(SLOT_COUNT);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_CHECK  = 5'b00010,
      S_WALK   = 5'b00100,
      S_MOVE   = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [bcl_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [DEVICE_BITS-1:0]     dev_ff, dev_in;
   logic [SECTOR_BITS-1:0]     sec_ff, sec_in;
   logic [SW-1:0]              slot_ff, slot_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;

   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             v1_ff, v1_in;
   logic             last1_ff, last1_in;
   logic [IDX_W-1:0] pos1_ff, pos1_in;
   logic             first_ff, first_in;
   logic             v2_ff, v2_in;
   logic             last2_ff, last2_in;
   logic [IDX_W-1:0] b2_ff, b2_in;
   logic [IDX_W-1:0] cand_ff, cand_in;
   logic             cand_ok_ff, cand_ok_in;
   logic [IDX_W-1:0] carry_ff, carry_in;

   bcl_pkg::status_type hold_status_ff, hold_status_in;
   logic [SW-1:0]       hold_slot_ff, hold_slot_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bcl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SW-1:0]                rsp_slot_ff, rsp_slot_in;

   logic             accept;
   logic             walking;
   logic             issue_more;
   logic             out_free;

   logic             rec_we, rec_re;
   logic [IDX_W-1:0] rec_waddr, rec_raddr;
   logic [REC_W-1:0] rec_wdata, rec_rd;
   logic             ord_we, ord_re;
   logic [IDX_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rd;

   logic             fin;
   bcl_pkg::status_type fin_status;
   logic [SW-1:0]    fin_slot;

   logic             hit, recyc, cand_now_ok, slot_bad;
   logic [IDX_W-1:0] cand_now;

   bcl_tag_store #(.WIDTH(REC_W), .DEPTH(SLOT_COUNT)) u_tags (
      .clock (clock),
      .reset (reset),
      .we    (rec_we),
      .waddr (rec_waddr),
      .wdata (rec_wdata),
      .re    (rec_re),
      .raddr (rec_raddr),
      .rdata (rec_rd)
   );

   bcl_order_store #(.DEPTH(SLOT_COUNT)) u_order (
      .clock (clock),
      .reset (reset),
      .we    (ord_we),
      .waddr (ord_waddr),
      .wdata (ord_wdata),
      .re    (ord_re),
      .raddr (ord_raddr),
      .rdata (ord_rd)
   );

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign accept            = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.slot_out = rsp_slot_ff;

   assign walking    = (state_ff == S_WALK) || (state_ff == S_MOVE);
   assign issue_more = (iss_ff < N_CNT);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   // record fields of the entry read last cycle
   assign hit = rec_rd[bcl_pkg::REC_USED]
             && (rec_rd[DEV_LO +: DEVICE_BITS] == dev_ff)
             && (rec_rd[SEC_LO +: SECTOR_BITS] == sec_ff);
   assign recyc       = !rec_rd[bcl_pkg::REC_BUSY] && !rec_rd[bcl_pkg::REC_DIRTY];
   assign cand_now_ok = cand_ok_ff || recyc;
   assign cand_now    = recyc ? b2_ff : cand_ff;
   assign slot_bad    = (mode_ff > bcl_pkg::MODE_WRITEBACK) || (8'(slot_ff) >= SLOT_LIMIT);

   // walk pipeline: issue order reads, then record reads one stage later
   always_comb begin
      iss_in   = walking ? (issue_more ? iss_ff + CNT_W'(1) : iss_ff) : '0;
      v1_in    = walking && issue_more;
      last1_in = (iss_ff == LAST_CNT);
      pos1_in  = iss_ff[IDX_W-1:0];
      v2_in    = (state_ff == S_WALK) && v1_ff;
      last2_in = last1_ff;
      b2_in    = ord_rd;
      ord_re    = walking && issue_more;
      ord_raddr = iss_ff[IDX_W-1:0];
      rec_re    = accept || ((state_ff == S_WALK) && v1_ff);
      rec_raddr = (state_ff == S_IDLE) ? IDX_W'(req_chan.slot) : ord_rd;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      dev_in         = dev_ff;
      sec_in         = sec_ff;
      slot_in        = slot_ff;
      idx_in         = idx_ff;
      first_in       = first_ff;
      cand_in        = cand_ff;
      cand_ok_in     = cand_ok_ff;
      carry_in       = carry_ff;
      hold_status_in = hold_status_ff;
      hold_slot_in   = hold_slot_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rec_we         = 1'b0;
      rec_waddr      = idx_ff;
      rec_wdata      = rec_rd;
      ord_we         = 1'b0;
      ord_waddr      = pos1_ff;
      ord_wdata      = first_ff ? idx_ff : carry_ff;
      fin            = 1'b0;
      fin_status     = bcl_pkg::ST_DONE;
      fin_slot       = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            cand_ok_in = 1'b0;
            first_in   = 1'b1;
            if (accept) begin
               mode_in  = req_chan.mode;
               dev_in   = DEVICE_BITS'(req_chan.dev);
               sec_in   = SECTOR_BITS'(req_chan.sector);
               slot_in  = req_chan.slot;
               idx_in   = IDX_W'(req_chan.slot);
               state_in = (req_chan.mode == bcl_pkg::MODE_GET) ? S_WALK : S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (slot_bad) begin
               fin        = 1'b1;
               fin_status = bcl_pkg::ST_ERROR;
            end else if (mode_ff == bcl_pkg::MODE_RELEASE) begin
               if (!rec_rd[bcl_pkg::REC_BUSY]) begin
                  fin        = 1'b1;
                  fin_status = bcl_pkg::ST_ERROR;
               end else begin
                  rec_we                       = 1'b1;
                  rec_wdata[bcl_pkg::REC_BUSY] = 1'b0;
                  state_in                     = S_MOVE;
               end
            end else if (mode_ff == bcl_pkg::MODE_FILL) begin
               rec_we                        = 1'b1;
               rec_wdata[bcl_pkg::REC_VALID] = 1'b1;
               fin                           = 1'b1;
            end else if (mode_ff == bcl_pkg::MODE_PIN) begin
               rec_we                        = 1'b1;
               rec_wdata[bcl_pkg::REC_DIRTY] = 1'b1;
               fin                           = 1'b1;
            end else begin
               fin = 1'b1;
               if (!rec_rd[bcl_pkg::REC_BUSY]) begin
                  fin_status = bcl_pkg::ST_ERROR;
               end else begin
                  rec_we                        = 1'b1;
                  rec_wdata[bcl_pkg::REC_DIRTY] = 1'b0;
               end
            end
         end
         S_WALK: begin
            if (v2_ff) begin
               priority if (hit) begin
                  fin      = 1'b1;
                  fin_slot = SW'(b2_ff);
                  if (rec_rd[bcl_pkg::REC_BUSY]) begin
                     fin_status = bcl_pkg::ST_WAIT;
                  end else begin
                     rec_we                       = 1'b1;
                     rec_waddr                    = b2_ff;
                     rec_wdata[bcl_pkg::REC_BUSY] = 1'b1;
                     fin_status = rec_rd[bcl_pkg::REC_VALID] ? bcl_pkg::ST_READY
                                                             : bcl_pkg::ST_NEEDREAD;
                  end
               end else if (last2_ff) begin
                  fin = 1'b1;
                  if (cand_now_ok) begin
                     // recycle the least recent free clean slot
                     rec_we                          = 1'b1;
                     rec_waddr                       = cand_now;
                     rec_wdata                       = '0;
                     rec_wdata[bcl_pkg::REC_USED]    = 1'b1;
                     rec_wdata[bcl_pkg::REC_BUSY]    = 1'b1;
                     rec_wdata[DEV_LO +: DEVICE_BITS] = dev_ff;
                     rec_wdata[SEC_LO +: SECTOR_BITS] = sec_ff;
                     fin_status = bcl_pkg::ST_NEEDREAD;
                     fin_slot   = SW'(cand_now);
                  end else begin
                     fin_status = bcl_pkg::ST_NONEFREE;
                     fin_slot   = '0;
                  end
               end else begin
                  cand_in    = cand_now;
                  cand_ok_in = cand_now_ok;
               end
            end
         end
         S_MOVE: begin
            // shift each entry one place back until the released slot is reached
            if (v1_ff) begin
               ord_we   = 1'b1;
               carry_in = ord_rd;
               first_in = 1'b0;
               if ((ord_rd == idx_ff) || last1_ff) begin
                  fin = 1'b1;
               end
            end
         end
         S_RESULT: begin
            fin        = 1'b1;
            fin_status = hold_status_ff;
            fin_slot   = hold_slot_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         if (out_free) begin
            rsp_status_in = fin_status;
            rsp_slot_in   = fin_slot;
            state_in      = S_IDLE;
         end else begin
            hold_status_in = fin_status;
            hold_slot_in   = fin_slot;
            state_in       = S_RESULT;
         end
      end
   end

   assign rsp_valid_in = (fin && out_free) || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         cand_ok_ff   <= 1'b0;
         first_ff     <= 1'b1;
         iss_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         cand_ok_ff   <= cand_ok_in;
         first_ff     <= first_in;
         iss_ff       <= iss_in;
      end
      mode_ff        <= mode_in;
      dev_ff         <= dev_in;
      sec_ff         <= sec_in;
      slot_ff        <= slot_in;
      idx_ff         <= idx_in;
      last1_ff       <= last1_in;
      pos1_ff        <= pos1_in;
      last2_ff       <= last2_in;
      b2_ff          <= b2_in;
      cand_ff        <= cand_in;
      carry_ff       <= carry_in;
      hold_status_ff <= hold_status_in;
      hold_slot_ff   <= hold_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   a_single_store_write: assert property (@(posedge clock) disable iff (reset)
      !(rec_we && ord_we))
      else $error("record and order memories written in the same cycle");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CHECK || state_ff == S_WALK))
      else $error("accepted item did not start work");

   a_front_gets_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE && v1_ff && first_ff) |-> (ord_waddr == '0 && ord_wdata == idx_ff))
      else $error("released slot not placed at the front of the recency list");

   a_record_write_state: assert property (@(posedge clock) disable iff (reset)
      rec_we |-> (state_ff == S_CHECK || state_ff == S_WALK))
      else $error("record write outside check or walk");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buffer cache LRU manager. Drives get, release,
// fill, pin, write-back and undefined-mode requests, tracks tags, flags and
// recency order in a local state copy, and checks every reply in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS          = 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_ITEMS   = 950;

   // Mode codes the block does not define
   localparam logic [bcl_pkg::MODE_W-1:0] MODE_RSVD5 = 3'd5;
   localparam logic [bcl_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [bcl_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

   typedef struct packed {
      bcl_pkg::status_type          status;
      logic [bcl_pkg::SLOT_W-1:0]   slot;
   } reply_type;

   // Cache state copy plus the replies still owed by the block
   class slot_ledger;
      bit                tag_used  [SLOTS];
      logic [1:0]        tag_dev   [SLOTS];
      logic [9:0]        tag_sec   [SLOTS];
      bit                busy      [SLOTS];
      bit                filled    [SLOTS];
      bit                dirty     [SLOTS];
      logic [3:0]        lru_order [SLOTS];
      reply_type         owed_replies [$];
      int unsigned       mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            tag_used[i]  = 0;
            tag_dev[i]   = '0;
            tag_sec[i]   = '0;
            busy[i]      = 0;
            filled[i]    = 0;
            dirty[i]     = 0;
            lru_order[i] = 4'(i);
         end
         mismatches = 0;
      endfunction

      function void move_to_front(int s);
         int p;
         p = 0;
         while (p < SLOTS && lru_order[p] != 4'(s)) p++;
         for (int i = p; i > 0; i--) lru_order[i] = lru_order[i-1];
         lru_order[0] = 4'(s);
      endfunction

      function reply_type lookup(logic [1:0] dev, logic [9:0] sector);
         reply_type r;
         int        b;
         // search from most recent down
         for (int i = 0; i < SLOTS; i++) begin
            b = lru_order[i];
            if (tag_used[b] && tag_dev[b] == dev && tag_sec[b] == sector) begin
               r.slot = 4'(b);
               if (busy[b]) begin
                  r.status = bcl_pkg::ST_WAIT;
               end else begin
                  busy[b]  = 1;
                  r.status = filled[b] ? bcl_pkg::ST_READY : bcl_pkg::ST_NEEDREAD;
               end
               return r;
            end
         end
         // recycle the least recent slot that is free and clean
         for (int i = SLOTS - 1; i >= 0; i--) begin
            b = lru_order[i];
            if (!busy[b] && !dirty[b]) begin
               tag_used[b] = 1;
               tag_dev[b]  = dev;
               tag_sec[b]  = sector;
               busy[b]     = 1;
               filled[b]   = 0;
               dirty[b]    = 0;
               r.status    = bcl_pkg::ST_NEEDREAD;
               r.slot      = 4'(b);
               return r;
            end
         end
         r.status = bcl_pkg::ST_NONEFREE;
         r.slot   = '0;
         return r;
      endfunction

      function void note_request(logic [2:0] mode, logic [1:0] dev,
                                 logic [9:0] sector, logic [3:0] slot);
         reply_type r;
         r.status = bcl_pkg::ST_DONE;
         r.slot   = slot;
         unique case (mode)
            bcl_pkg::MODE_GET: r = lookup(dev, sector);
            bcl_pkg::MODE_RELEASE: begin
               if (!busy[slot]) begin
                  r.status = bcl_pkg::ST_ERROR;
               end else begin
                  move_to_front(slot);
                  busy[slot] = 0;
               end
            end
            bcl_pkg::MODE_FILL: filled[slot] = 1;
            bcl_pkg::MODE_PIN:  dirty[slot]  = 1;
            bcl_pkg::MODE_WRITEBACK: begin
               if (!busy[slot]) r.status = bcl_pkg::ST_ERROR;
               else dirty[slot] = 0;
            end
            default: r.status = bcl_pkg::ST_ERROR;
         endcase
         owed_replies.push_back(r);
      endfunction

      function void check_reply(logic [2:0] status, logic [3:0] slot_out);
         reply_type want;
         if (owed_replies.size() == 0) begin
            $error("unexpected reply: status %0d, slot_out %0d", status, slot_out);
            mismatches++;
            return;
         end
         want = owed_replies.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (slot_out !== want.slot) begin
            $error("slot_out: expected %0d, actual %0d", want.slot, slot_out);
            mismatches++;
         end
      endfunction

      function int pending();
         return owed_replies.size();
      endfunction

      function int busy_count();
         int n;
         n = 0;
         for (int i = 0; i < SLOTS; i++) n += busy[i];
         return n;
      endfunction

      // random busy slot, or -1 when none is held
      function int pick_busy();
         int held [$];
         for (int i = 0; i < SLOTS; i++) if (busy[i]) held.push_back(i);
         if (held.size() == 0) return -1;
         return held[$urandom_range(0, held.size() - 1)];
      endfunction
   endclass

   logic clock;
   logic reset;

   bcl_req_if #(.DEVICE_BITS(2), .SECTOR_BITS(10)) req_chan ();
   bcl_rsp_if rsp_chan ();

   buffer_cache_lru_manager #(
      .SLOT_COUNT(SLOTS), .SECTOR_BITS(10), .DEVICE_BITS(2)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   slot_ledger  ledger = new();
   bit          gaps_on;
   bit          stall_on;
   bit          hold_req;
   int          stall_left;
   int unsigned quiet_cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Reply first: a reply seen at this edge belongs to an earlier item
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            ledger.check_reply(rsp_chan.status, rsp_chan.slot_out);
         if (req_chan.valid && req_chan.ready)
            ledger.note_request(req_chan.mode, req_chan.dev, req_chan.sector,
                                req_chan.slot);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready)
                || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // Reply side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready = 0;
      stall_left     = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 0;
         end else if (hold_req) begin
            hold_req   = 0;
            stall_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_chan.ready <= 0;
         end else begin
            rsp_chan.ready <= 1;
         end
      end
   end

   // Call at a falling edge; returns at the falling edge after acceptance
   task automatic offer_request(logic [2:0] mode, logic [1:0] dev,
                                logic [9:0] sector, logic [3:0] slot);
      req_chan.valid  <= 1;
      req_chan.mode   <= mode;
      req_chan.dev    <= dev;
      req_chan.sector <= sector;
      req_chan.slot   <= slot;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic offer_random();
      int         pick;
      int         s;
      logic [2:0] m;
      logic [1:0] d;
      logic [9:0] sec;
      logic [3:0] sl;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      pick = $urandom_range(0, 99);
      d    = 2'($urandom_range(0, 3));
      // mostly a small set of hot tags so hits and recycling both happen
      sec  = ($urandom_range(0, 6) == 0) ? 10'($urandom)
                                           : 10'(171 * $urandom_range(0, 5));
      sl   = 4'($urandom);
      s    = ledger.pick_busy();
      m    = bcl_pkg::MODE_GET;
      if (s >= 0 && (pick < 30 || ledger.busy_count() > 10)) begin
         sl = 4'(s);
         m  = (ledger.dirty[s] && $urandom_range(0, 2) != 0) ? bcl_pkg::MODE_WRITEBACK
                                                              : bcl_pkg::MODE_RELEASE;
      end else if (pick < 65) begin
         m = bcl_pkg::MODE_GET;
      end else if (pick < 90) begin
         if (s >= 0) sl = 4'(s);
         m = (pick < 76) ? bcl_pkg::MODE_FILL
           : (pick < 83) ? bcl_pkg::MODE_PIN : bcl_pkg::MODE_WRITEBACK;
      end else if (pick < 96) begin
         m = pick[0] ? bcl_pkg::MODE_RELEASE : bcl_pkg::MODE_WRITEBACK;
      end else begin
         m = 3'($urandom);
         // keep stray pins from locking idle slots dirty
         if (m == bcl_pkg::MODE_PIN) begin
            if (s >= 0) sl = 4'(s);
            else m = bcl_pkg::MODE_FILL;
         end
      end
      offer_request(m, d, sec, sl);
   endtask

   initial begin
      reset           = 1;
      req_chan.valid  = 0;
      req_chan.mode   = bcl_pkg::MODE_GET;
      req_chan.dev    = '0;
      req_chan.sector = '0;
      req_chan.slot   = '0;
      gaps_on         = 0;
      stall_on        = 1;
      hold_req        = 0;
      quiet_cycles    = 0;
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      offer_request(bcl_pkg::MODE_GET,       2'd3, 10'd1023, 4'd0);
      offer_request(bcl_pkg::MODE_GET,       2'd3, 10'd1023, 4'd0);
      offer_request(bcl_pkg::MODE_FILL,      2'd0, 10'd0,    4'd15);
      offer_request(bcl_pkg::MODE_RELEASE,   2'd0, 10'd0,    4'd15);
      offer_request(bcl_pkg::MODE_GET,       2'd3, 10'd1023, 4'd0);
      offer_request(bcl_pkg::MODE_PIN,       2'd0, 10'd0,    4'd15);
      offer_request(bcl_pkg::MODE_WRITEBACK, 2'd0, 10'd0,    4'd15);
      offer_request(bcl_pkg::MODE_PIN,       2'd0, 10'd0,    4'd15);
      offer_request(bcl_pkg::MODE_RELEASE,   2'd0, 10'd0,    4'd15);
      offer_request(bcl_pkg::MODE_GET,       2'd0, 10'd0,    4'd0);
      offer_request(bcl_pkg::MODE_RELEASE,   2'd0, 10'd0,    4'd14);
      offer_request(bcl_pkg::MODE_WRITEBACK, 2'd0, 10'd0,    4'd14);
      offer_request(bcl_pkg::MODE_RELEASE,   2'd0, 10'd0,    4'd14);
      offer_request(bcl_pkg::MODE_GET,       2'd3, 10'd1023, 4'd0);
      offer_request(bcl_pkg::MODE_WRITEBACK, 2'd0, 10'd0,    4'd15);
      offer_request(bcl_pkg::MODE_RELEASE,   2'd0, 10'd0,    4'd15);
      offer_request(MODE_RSVD5,              2'd3, 10'd1023, 4'd10);
      offer_request(MODE_RSVD6,              2'd1, 10'd341,  4'd5);
      offer_request(MODE_RSVD7,              2'd2, 10'd682,  4'd15);
      offer_request(bcl_pkg::MODE_FILL,      2'd0, 10'd0,    4'd0);
      offer_request(bcl_pkg::MODE_GET,       2'd1, 10'd682,  4'd0);
      offer_request(bcl_pkg::MODE_RELEASE,   2'd0, 10'd0,    4'd13);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 100 == 0) begin
            gaps_on  = ($urandom_range(0, 2) != 0);
            stall_on = ($urandom_range(0, 2) != 0);
         end
         offer_random();
      end

      // Hold the reply side and pile up gets until no slot can be recycled
      gaps_on  = 0;
      stall_on = 0;
      hold_req = 1;
      for (int k = 0; k < 18; k++)
         offer_request(bcl_pkg::MODE_GET, 2'd2, 10'(900 + k), '0);
      req_chan.valid <= 0;
      while (ledger.pending() != 0) @(posedge clock);
      @(negedge clock);
      for (int k = 0; k < SLOTS; k++) begin
         if (ledger.busy[k]) begin
            offer_request(bcl_pkg::MODE_WRITEBACK, 2'd0, 10'd0, 4'(k));
            offer_request(bcl_pkg::MODE_RELEASE,   2'd0, 10'd0, 4'(k));
         end
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) offer_random();

      req_chan.valid <= 0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
